FILE: rtl/arbpt_pkg.sv
// ----------------------------------------------------------------------------
// arbpt_pkg: shared types and constants for the byte patch table
// Operation codes, field widths, default sizes and controller/datapath structs.
// ----------------------------------------------------------------------------
package arbpt_pkg;

    // Default table geometry.
    localparam int SLOT_COUNT_DEF = 8;
    localparam int SLOT_BYTES_DEF = 1024;

    // Fixed field widths of the item and result beats.
    localparam int OP_W    = 3;
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 8;
    localparam int BIDX_W  = 10;
    localparam int LEN_W   = 10;
    localparam int SIDX_W  = 3;
    localparam int ACT_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_INSTALL= 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_GET    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOOK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // register the accepted item
        logic exec;         // apply the operation, start the patch lookup
        logic finish_read;  // form the read result from the patch memory
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;      // registered item is a read
        logic out_free;     // result register can take a new beat
    } t_status;

endpackage

FILE: rtl/arbpt_ram.sv
// ----------------------------------------------------------------------------
// arbpt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/arbpt_ctrl.sv
// ----------------------------------------------------------------------------
// arbpt_ctrl: sequencing state machine
// Takes one item, executes it, waits for the patch memory on reads and for a free result register.
// ----------------------------------------------------------------------------
module arbpt_ctrl
    import arbpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.is_read) begin
                    n_state = ST_LOOK;
                end else if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOOK: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.capture     = 1'b0;
        o_cmd.exec        = 1'b0;
        o_cmd.finish_read = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                // A read only starts the lookup here, so it need not wait.
                o_cmd.exec = i_status.is_read || i_status.out_free;
            end
            ST_LOOK: begin
                o_cmd.finish_read = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/arbpt_datapath.sv
// ----------------------------------------------------------------------------
// arbpt_datapath: slot table, patch memory and result register
// Holds the overlay stack, matches read addresses and builds result beats.
// ----------------------------------------------------------------------------
module arbpt_datapath
    import arbpt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [OP_W-1:0]   i_op,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_underlying_byte,
    input  logic              i_clean,
    input  logic [BIDX_W-1:0] i_byte_index,
    input  logic [DATA_W-1:0] i_load_byte,
    input  logic [ADDR_W-1:0] i_patch_start,
    input  logic [LEN_W-1:0]  i_patch_length,
    input  logic [SIDX_W-1:0] i_slot_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_read_byte,
    output logic              o_from_patch,
    output logic              o_success,
    output logic [ACT_W-1:0]  o_active_slots,
    output logic [ADDR_W-1:0] o_reported_start,
    output logic [LEN_W-1:0]  o_reported_length
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BYTE_W = $clog2(SLOT_BYTES);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W  = (BYTE_W + 1 > BIDX_W) ? BYTE_W + 1 : BIDX_W;
    localparam int GIDX_W = (SLOT_W > SIDX_W) ? SLOT_W : SIDX_W;
    localparam int RAM_DEPTH = SLOT_COUNT * (1 << BYTE_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // Registered item.
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_under;
    logic              r_clean;
    logic [BIDX_W-1:0] r_bidx;
    logic [DATA_W-1:0] r_lbyte;
    logic [ADDR_W-1:0] r_pstart;
    logic [LEN_W-1:0]  r_plen;
    logic [SIDX_W-1:0] r_sidx;

    // Overlay stack.
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [ADDR_W-1:0] r_slot_start [SLOT_COUNT];
    logic [LEN_W-1:0]  r_slot_len   [SLOT_COUNT];

    logic              r_hit;

    // Result register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_byte;
    logic              r_from_patch;
    logic              r_success;
    logic [ACT_W-1:0]  r_active;
    logic [ADDR_W-1:0] r_rep_start;
    logic [LEN_W-1:0]  r_rep_len;

    logic              w_full;
    logic              w_load_we;
    logic              w_inst_ok;
    logic              w_get_ok;
    logic [IDX_W-1:0]  w_bidx_ext;
    logic [IDX_W-1:0]  w_plen_ext;
    logic [GIDX_W-1:0] w_sidx_ext;
    logic [SLOT_W-1:0] w_top_slot;
    logic [ADDR_W-1:0] w_diff  [SLOT_COUNT];
    logic              w_cover [SLOT_COUNT];
    logic              w_found;
    logic [SLOT_W-1:0] w_hit_slot;
    logic [BYTE_W-1:0] w_hit_off;
    logic              w_ram_re;
    logic [DATA_W-1:0] w_ram_q;

    assign o_status.is_read  = (r_op == OP_READ);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_op);
            r_addr   <= i_address;
            r_under  <= i_underlying_byte;
            r_clean  <= i_clean;
            r_bidx   <= i_byte_index;
            r_lbyte  <= i_load_byte;
            r_pstart <= i_patch_start;
            r_plen   <= i_patch_length;
            r_sidx   <= i_slot_index;
        end
    end

    assign w_full     = (r_count == CNT_W'(SLOT_COUNT));
    assign w_bidx_ext = IDX_W'(r_bidx);
    assign w_plen_ext = IDX_W'(r_plen);
    assign w_sidx_ext = GIDX_W'(r_sidx);
    assign w_top_slot = r_count[SLOT_W-1:0];

    always_comb begin
        n_count   = r_count;
        w_load_we = 1'b0;
        w_inst_ok = 1'b0;
        w_get_ok  = 1'b0;
        case (r_op)
            OP_LOAD: begin
                w_load_we = !w_full && (w_bidx_ext < IDX_W'(SLOT_BYTES));
            end
            OP_INSTALL: begin
                w_inst_ok = !w_full && (w_plen_ext < IDX_W'(SLOT_BYTES));
                if (w_inst_ok) begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_GET: begin
                w_get_ok = (32'(r_sidx) < 32'(SLOT_COUNT)) && (32'(r_sidx) < 32'(r_count));
            end
            default: begin
            end
        endcase
    end

    // Range match of every slot in parallel; the newest covering slot wins.
    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            w_diff[s]  = r_addr - r_slot_start[s];
            w_cover[s] = (32'(s) < 32'(r_count)) && (r_addr >= r_slot_start[s]) &&
                         (w_diff[s] < ADDR_W'(r_slot_len[s]));
        end
    end

    always_comb begin
        w_found    = 1'b0;
        w_hit_slot = '0;
        w_hit_off  = '0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (w_cover[s]) begin
                w_found    = 1'b1;
                w_hit_slot = SLOT_W'(s);
                w_hit_off  = w_diff[s][BYTE_W-1:0];
            end
        end
    end

    assign w_ram_re = i_cmd.exec && (r_op == OP_READ);

    arbpt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_patch_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && w_load_we),
        .i_waddr (RAM_AW'({w_top_slot, w_bidx_ext[BYTE_W-1:0]})),
        .i_wdata (r_lbyte),
        .i_re    (w_ram_re),
        .i_raddr (RAM_AW'({w_hit_slot, w_hit_off})),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_inst_ok) begin
            r_slot_start[w_top_slot] <= r_pstart;
            r_slot_len[w_top_slot]   <= r_plen;
        end
        if (w_ram_re) begin
            r_hit <= w_found && !r_clean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.exec && (r_op != OP_READ)) || i_cmd.finish_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_op != OP_READ)) begin
            r_read_byte  <= '0;
            r_from_patch <= 1'b0;
            r_success    <= w_inst_ok || w_get_ok;
            r_active     <= ACT_W'(n_count);
            r_rep_start  <= w_get_ok ? r_slot_start[w_sidx_ext[SLOT_W-1:0]] : '0;
            r_rep_len    <= w_get_ok ? r_slot_len[w_sidx_ext[SLOT_W-1:0]] : '0;
        end else if (i_cmd.finish_read) begin
            r_read_byte  <= r_hit ? w_ram_q : r_under;
            r_from_patch <= r_hit;
            r_success    <= 1'b0;
            r_active     <= ACT_W'(r_count);
            r_rep_start  <= '0;
            r_rep_len    <= '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_byte       = r_read_byte;
    assign o_from_patch      = r_from_patch;
    assign o_success         = r_success;
    assign o_active_slots    = r_active;
    assign o_reported_start  = r_rep_start;
    assign o_reported_length = r_rep_len;

endmodule

FILE: rtl/address_range_byte_patch_table.sv
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered, then executed, and its result beat is
// registered; a read first registers the patch memory data, then its result.
// One item is in flight at a time and a result stall holds it in execution;
// the result register lets the next item enter before the last beat is taken.
// Reset clears the slot count, the controller and the result valid; the patch
// memory is not cleared, and only bytes that were loaded may be read back.
// ----------------------------------------------------------------------------
// address_range_byte_patch_table: stacked byte patch overlays
// Loads, installs, removes and reports overlay slots and resolves byte reads.
// ----------------------------------------------------------------------------
module address_range_byte_patch_table
    import arbpt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Item channel.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_underlying_byte,
    input  logic              i_clean,
    input  logic [BIDX_W-1:0] i_byte_index,
    input  logic [DATA_W-1:0] i_load_byte,
    input  logic [ADDR_W-1:0] i_patch_start,
    input  logic [LEN_W-1:0]  i_patch_length,
    input  logic [SIDX_W-1:0] i_slot_index,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_read_byte,
    output logic              o_from_patch,
    output logic              o_success,
    output logic [ACT_W-1:0]  o_active_slots,
    output logic [ADDR_W-1:0] o_reported_start,
    output logic [LEN_W-1:0]  o_reported_length
);

    // The controller steps each beat through capture, execution and, for a
    // read, the wait on the patch memory. The datapath owns all storage.
    t_cmd    w_cmd;
    t_status w_status;

    arbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Slot registers are compared against the read address in parallel; the
    // newest covering slot selects the patch byte from the patch memory.
    arbpt_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_op              (i_op),
        .i_address         (i_address),
        .i_underlying_byte (i_underlying_byte),
        .i_clean           (i_clean),
        .i_byte_index      (i_byte_index),
        .i_load_byte       (i_load_byte),
        .i_patch_start     (i_patch_start),
        .i_patch_length    (i_patch_length),
        .i_slot_index      (i_slot_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_read_byte       (o_read_byte),
        .o_from_patch      (o_from_patch),
        .o_success         (o_success),
        .o_active_slots    (o_active_slots),
        .o_reported_start  (o_reported_start),
        .o_reported_length (o_reported_length)
    );

endmodule

FILE: dv/tb_address_range_byte_patch_table.sv
// ----------------------------------------------------------------------------
// tb_address_range_byte_patch_table: self-checking bench for the patch table
// Drives op beats through the item channel and predicts every result beat.
// Loads, installs, removes, clears, gets and reads are checked field by field.
// Both channels idle and stall at random, and one long output stall fills the
// block so that it has to hold off its input.
// ----------------------------------------------------------------------------
module tb_address_range_byte_patch_table;
    import arbpt_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int SLOT_SIZE    = SLOT_BYTES_DEF;
    localparam int ITEM_TARGET  = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_STALL   = 150;

    // The two op codes that the package leaves unassigned.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] underlying_byte;
        logic              clean;
        logic [BIDX_W-1:0] byte_index;
        logic [DATA_W-1:0] load_byte;
        logic [ADDR_W-1:0] patch_start;
        logic [LEN_W-1:0]  patch_length;
        logic [SIDX_W-1:0] slot_index;
    } t_patch_item;

    typedef struct {
        logic [DATA_W-1:0] read_byte;
        logic              from_patch;
        logic              success;
        logic [ACT_W-1:0]  active_slots;
        logic [ADDR_W-1:0] reported_start;
        logic [LEN_W-1:0]  reported_length;
    } t_patch_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_op;
    logic [ADDR_W-1:0] i_address;
    logic [DATA_W-1:0] i_underlying_byte;
    logic              i_clean;
    logic [BIDX_W-1:0] i_byte_index;
    logic [DATA_W-1:0] i_load_byte;
    logic [ADDR_W-1:0] i_patch_start;
    logic [LEN_W-1:0]  i_patch_length;
    logic [SIDX_W-1:0] i_slot_index;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DATA_W-1:0] o_read_byte;
    logic              o_from_patch;
    logic              o_success;
    logic [ACT_W-1:0]  o_active_slots;
    logic [ADDR_W-1:0] o_reported_start;
    logic [LEN_W-1:0]  o_reported_length;

    address_range_byte_patch_table i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_address         (i_address),
        .i_underlying_byte (i_underlying_byte),
        .i_clean           (i_clean),
        .i_byte_index      (i_byte_index),
        .i_load_byte       (i_load_byte),
        .i_patch_start     (i_patch_start),
        .i_patch_length    (i_patch_length),
        .i_slot_index      (i_slot_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_read_byte       (o_read_byte),
        .o_from_patch      (o_from_patch),
        .o_success         (o_success),
        .o_active_slots    (o_active_slots),
        .o_reported_start  (o_reported_start),
        .o_reported_length (o_reported_length)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of the overlay table. The byte_loaded map remembers which
    // patch bytes were ever written, since the patch memory is never cleared
    // and a read of a byte that was never loaded has no defined answer.
    // ------------------------------------------------------------------------
    int                model_count;
    bit                model_enabled [SLOTS];
    logic [ADDR_W-1:0] model_start   [SLOTS];
    logic [LEN_W-1:0]  model_length  [SLOTS];
    logic [DATA_W-1:0] model_bytes   [SLOTS][SLOT_SIZE];
    bit                byte_loaded   [SLOTS][SLOT_SIZE];

    // Result beats predicted for accepted items, oldest first.
    t_patch_result expected_results[$];

    bit idle_on;        // random gaps on both channels when set
    int long_hold;      // request for one long output stall, in cycles
    int items_sent;
    int results_checked;
    int error_count;
    int cycle_count;
    int reads_patched;
    int installs_accepted;
    int installs_refused;

    // ------------------------------------------------------------------------
    // Clock and reset.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog bounds the run even if a handshake hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor. A window covers an address at or above its start whose
    // distance from the start is below the length, so it never wraps past the
    // top of the address space.
    // ------------------------------------------------------------------------
    function automatic bit window_covers(int s, logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] span;
        span = addr - model_start[s];
        return model_enabled[s] && (addr >= model_start[s]) && (span < model_length[s]);
    endfunction

    // True when an overlay read of this address would land on a patch byte
    // that was never loaded. Only the newest covering window matters.
    function automatic bit read_hits_unloaded(logic [ADDR_W-1:0] addr);
        int                hit;
        logic [ADDR_W-1:0] off;
        hit = -1;
        for (int s = 0; s < model_count; s++) begin
            if (window_covers(s, addr)) hit = s;
        end
        if (hit < 0) return 1'b0;
        off = addr - model_start[hit];
        return !byte_loaded[hit][off[BIDX_W-1:0]];
    endfunction

    task automatic predict_patch_table(input t_patch_item it, output t_patch_result r);
        logic [ADDR_W-1:0] off;
        r = '{default: '0};
        case (it.op)
            OP_READ: begin
                r.read_byte = it.underlying_byte;
                if (!it.clean) begin
                    // Later slots are newer, so the last covering one wins.
                    for (int s = 0; s < model_count; s++) begin
                        if (window_covers(s, it.address)) begin
                            off = it.address - model_start[s];
                            r.read_byte = model_bytes[s][off[BIDX_W-1:0]];
                            r.from_patch = 1'b1;
                        end
                    end
                end
                if (r.from_patch) reads_patched++;
            end
            OP_LOAD: begin
                // The pending slot is the one just above the installed ones.
                if (model_count < SLOTS) begin
                    model_bytes[model_count][it.byte_index] = it.load_byte;
                    byte_loaded[model_count][it.byte_index] = 1'b1;
                end
            end
            OP_INSTALL: begin
                if (model_count < SLOTS && it.patch_length < SLOT_SIZE) begin
                    model_enabled[model_count] = 1'b1;
                    model_start[model_count]   = it.patch_start;
                    model_length[model_count]  = it.patch_length;
                    model_count++;
                    r.success = 1'b1;
                    installs_accepted++;
                end else begin
                    installs_refused++;
                end
            end
            OP_REMOVE: begin
                if (model_count > 0) begin
                    model_count--;
                    model_enabled[model_count] = 1'b0;
                end
            end
            OP_CLEAR: begin
                model_count = 0;
                foreach (model_enabled[k]) model_enabled[k] = 1'b0;
            end
            OP_GET: begin
                if (model_enabled[it.slot_index]) begin
                    r.success         = 1'b1;
                    r.reported_start  = model_start[it.slot_index];
                    r.reported_length = model_length[it.slot_index];
                end
            end
            default: begin
                // Spare op codes change nothing and report only the count.
            end
        endcase
        r.active_slots = model_count[ACT_W-1:0];
    endtask

    // ------------------------------------------------------------------------
    // Item channel driver. Inputs change on the falling edge; acceptance is
    // seen on the rising edge. Valid stays high from one beat to the next
    // when no gap is drawn, so it is never dropped and raised in one step.
    // Every field is randomized, also those the op ignores.
    // ------------------------------------------------------------------------
    function automatic t_patch_item random_item();
        t_patch_item it;
        it.op              = OP_W'($urandom_range(0, 7));
        it.address         = $urandom;
        it.underlying_byte = DATA_W'($urandom);
        it.clean           = 1'($urandom);
        it.byte_index      = BIDX_W'($urandom);
        it.load_byte       = DATA_W'($urandom);
        it.patch_start     = $urandom;
        it.patch_length    = LEN_W'($urandom);
        it.slot_index      = SIDX_W'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_patch_item item_in);
        t_patch_item   it;
        t_patch_result want;
        int            gap;
        it = item_in;
        // Never read a patch byte that no load has written: such a read
        // bypasses the overlays instead.
        if (it.op == OP_READ && !it.clean && read_hits_unloaded(it.address)) begin
            it.clean = 1'b1;
        end
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op              = it.op;
        i_address         = it.address;
        i_underlying_byte = it.underlying_byte;
        i_clean           = it.clean;
        i_byte_index      = it.byte_index;
        i_load_byte       = it.load_byte;
        i_patch_start     = it.patch_start;
        i_patch_length    = it.patch_length;
        i_slot_index      = it.slot_index;
        i_in_valid        = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_patch_table(it, want);
        expected_results.push_back(want);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic do_read(input logic [ADDR_W-1:0] addr, input logic clean);
        t_patch_item it;
        it         = random_item();
        it.op      = OP_READ;
        it.address = addr;
        it.clean   = clean;
        send_item(it);
    endtask

    task automatic do_load(input int idx, input logic [DATA_W-1:0] data);
        t_patch_item it;
        it            = random_item();
        it.op         = OP_LOAD;
        it.byte_index = BIDX_W'(idx);
        it.load_byte  = data;
        send_item(it);
    endtask

    task automatic do_install(input logic [ADDR_W-1:0] start, input int len);
        t_patch_item it;
        it              = random_item();
        it.op           = OP_INSTALL;
        it.patch_start  = start;
        it.patch_length = LEN_W'(len);
        send_item(it);
    endtask

    // Remove, clear, get and the spare codes; the slot only matters for get.
    task automatic do_op(input logic [OP_W-1:0] op, input int slot);
        t_patch_item it;
        it            = random_item();
        it.op         = op;
        it.slot_index = SIDX_W'(slot);
        send_item(it);
    endtask

    // ------------------------------------------------------------------------
    // Result channel. Ready is drawn per beat; a long hold requested by a
    // test replaces the current stall and is counted down here.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        i_out_ready = 1'b0;
        stall       = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold > 0) begin
                stall     = long_hold;
                long_hold = 0;
            end
            i_out_ready = (stall == 0);
            if (stall > 0) stall--;
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) stall = idle_on ? $urandom_range(0, 9) : 0;
        end
    end

    task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Each result beat is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_patch_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat arrived with no expectation pending");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("read_byte", ADDR_W'(want.read_byte), ADDR_W'(o_read_byte));
                check_field("from_patch", ADDR_W'(want.from_patch), ADDR_W'(o_from_patch));
                check_field("success", ADDR_W'(want.success), ADDR_W'(o_success));
                check_field("active_slots", ADDR_W'(want.active_slots),
                            ADDR_W'(o_active_slots));
                check_field("reported_start", want.reported_start, o_reported_start);
                check_field("reported_length", ADDR_W'(want.reported_length),
                            ADDR_W'(o_reported_length));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers for the random part.
    // ------------------------------------------------------------------------

    // Reads mostly aim at the edges of an installed window, a couple of bytes
    // past either end included, so that hits, misses and overlaps all occur.
    function automatic logic [ADDR_W-1:0] pick_read_address();
        int s;
        int off;
        if (model_count == 0 || $urandom_range(0, 5) == 0) return $urandom;
        s = $urandom_range(0, model_count - 1);
        if ($urandom_range(0, 1) == 1) begin
            off = int'($urandom_range(0, 13)) - 2;
        end else begin
            off = int'(model_length[s]) + 1 - int'($urandom_range(0, 13));
        end
        return model_start[s] + ADDR_W'(off);
    endfunction

    // Starts cluster near zero, near the top address and on top of existing
    // windows, so that windows overlap and reach the end of the space.
    function automatic logic [ADDR_W-1:0] pick_start();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            2: begin
                if (model_count == 0) return $urandom_range(0, 64);
                return model_start[$urandom_range(0, model_count - 1)] + $urandom_range(0, 8);
            end
            default: return $urandom_range(0, 64);
        endcase
    endfunction

    // A well-formed overlay: load the window's bytes, then commit it. Long
    // windows only get their first and last eight bytes loaded to keep runs short.
    task automatic build_overlay(input int len, input logic [ADDR_W-1:0] start);
        bit sparse;
        sparse = (len > 32);
        for (int k = 0; k < len; k++) begin
            if (!sparse || k < 8 || k >= len - 8) do_load(k, DATA_W'($urandom));
        end
        // Now and then a byte is loaded twice; the later value must win.
        if (len > 0 && $urandom_range(0, 3) == 0) begin
            do_load($urandom_range(0, len - 1), DATA_W'($urandom));
        end
        do_install(start, len);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Everything on an empty table: reads pass the underlying byte through,
    // a get finds nothing, a remove does nothing, spare ops report the count.
    task automatic test_empty_table();
        do_read(32'h0000_1234, 1'b0);
        do_read(32'hFFFF_FFFF, 1'b1);
        do_op(OP_GET, 7);
        do_op(OP_REMOVE, 0);
        do_op(OP_SPARE_LO, 0);
        do_op(OP_SPARE_HI, 0);
    endtask

    // Two overlapping windows at the top of the address space. The newer one
    // is the longest allowed and ends exactly on the top address; neither may
    // wrap to address zero.
    task automatic test_overlays();
        do_load(0, 8'h00);
        do_load(1, 8'hFF);
        do_install(32'hFFFF_FFFE, 2);
        do_load(0, 8'hA5);
        do_load(SLOT_SIZE - 2, 8'h5A);
        do_install(32'hFFFF_FC01, SLOT_SIZE - 1);
        do_read(32'hFFFF_FFFF, 1'b0);
        do_read(32'h0000_0000, 1'b0);
        do_read(32'hFFFF_FC01, 1'b0);
        do_read(32'hFFFF_FC00, 1'b0);
        do_op(OP_GET, 1);
        // After the newer window goes, the older one shows through again.
        do_op(OP_REMOVE, 0);
        do_read(32'hFFFF_FFFE, 1'b0);
        do_read(32'hFFFF_FFFF, 1'b1);
        do_op(OP_GET, 0);
    endtask

    // Fill the table with empty windows, then try to load and install into
    // it, remove the top slot and clear the rest.
    task automatic test_full_table();
        while (model_count < SLOTS) do_install($urandom, 0);
        do_load(3, 8'h77);
        do_install(32'h0000_0040, 5);
        do_op(OP_GET, SLOTS - 1);
        do_op(OP_REMOVE, 0);
        do_op(OP_GET, SLOTS - 1);
        do_op(OP_CLEAR, 0);
        do_op(OP_GET, 0);
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so
    // the result register fills and the block must stall its item channel.
    task automatic test_output_stall();
        bit saved_idle;
        saved_idle = idle_on;
        idle_on    = 1'b0;
        build_overlay(6, 32'h0000_2000);
        long_hold = LONG_STALL;
        repeat (15) begin
            do_read(pick_read_address(), 1'b0);
            do_op(OP_GET, $urandom_range(0, SLOTS - 1));
        end
        idle_on = saved_idle;
    endtask

    // Mostly well-formed overlay builds and reads against them, mixed with
    // removes, clears, gets, stray installs and fully random beats.
    task automatic run_random_traffic();
        int pick;
        int len;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 30 && model_count < SLOTS) begin
                case ($urandom_range(0, 19))
                    0:       len = 0;
                    1:       len = $urandom_range(200, SLOT_SIZE - 1);
                    default: len = $urandom_range(1, 24);
                endcase
                build_overlay(len, pick_start());
            end else if (pick < 65) begin
                repeat ($urandom_range(1, 8)) begin
                    do_read(pick_read_address(), $urandom_range(0, 7) == 0);
                end
            end else if (pick < 77) begin
                do_op(OP_REMOVE, $urandom);
            end else if (pick < 79) begin
                do_op(OP_CLEAR, $urandom);
            end else if (pick < 89) begin
                do_op(OP_GET, $urandom_range(0, SLOTS - 1));
            end else if (pick < 92) begin
                do_install(pick_start(), $urandom_range(0, SLOT_SIZE - 1));
            end else begin
                send_item(random_item());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_op              = OP_READ;
        i_address         = '0;
        i_underlying_byte = '0;
        i_clean           = 1'b0;
        i_byte_index      = '0;
        i_load_byte       = '0;
        i_patch_start     = '0;
        i_patch_length    = '0;
        i_slot_index      = '0;
        idle_on           = 1'b1;
        long_hold         = 0;
        model_count       = 0;
        foreach (model_enabled[k]) begin
            model_enabled[k] = 1'b0;
            model_start[k]   = '0;
            model_length[k]  = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_overlays();
        test_full_table();
        test_output_stall();
        run_random_traffic();

        // All beats are in; let the remaining results drain.
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items and checked %0d results; %0d reads came from overlays.",
                 items_sent, results_checked, reads_patched);
        $display("Installs committed: %0d, refused: %0d; one long output stall included.",
                 installs_accepted, installs_refused);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
